FILE: rtl/four_function_calculator_core_defines.svh
// Assertion macros for the calculator core
`ifndef FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("calculator core assertion failed");
`define FFC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("calculator core forbidden condition seen");
`else
`define FFC_ASSERT(label, prop)
`define FFC_ASSERT_NEVER(label, expr)
`endif

`endif

FILE: rtl/ffc_pkg.sv
// Shared types and constants for the calculator core
`default_nettype none

package ffc_pkg;

    localparam int DISPLAY_WIDTH = 64;
    localparam logic [3:0] RADIX = 4'd10;

    typedef enum logic [2:0] {
        CMD_DIGIT  = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_SUB    = 3'd3,
        CMD_MUL    = 3'd4,
        CMD_DIV    = 3'd5,
        CMD_EQUALS = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } op_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] digit_value;
    } key_t;

    typedef struct packed {
        logic signed [DISPLAY_WIDTH-1:0] display_value;
        logic                            divide_error;
    } result_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    function automatic op_t cmd_to_op(input cmd_t cmd);
        op_t op;
        case (cmd)
            CMD_ADD: op = OP_ADD;
            CMD_SUB: op = OP_SUB;
            CMD_MUL: op = OP_MUL;
            CMD_DIV: op = OP_DIV;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ffc_seq_alu.sv
// Shared add/subtract, iterative shift-add multiply and restoring divide unit
`default_nettype none

module ffc_seq_alu #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  ffc_pkg::alu_req_t              req,
    input  wire        [VALUE_WIDTH-1:0]   a,
    input  wire        [VALUE_WIDTH-1:0]   b,
    output ffc_pkg::alu_rsp_t              rsp,
    output logic       [VALUE_WIDTH-1:0]   result
);
    import ffc_pkg::*;

    localparam int W    = VALUE_WIDTH;
    localparam int CntW = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_FIX,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    acc_reg, acc_next;      // product, or remainder
    logic [W-1:0]    mcand_reg, mcand_next;  // multiplicand, or divisor
    logic [W-1:0]    mplier_reg, mplier_next; // multiplier, or dividend/quotient
    logic            neg_reg, neg_next;
    logic            dz_reg, dz_next;
    logic [W-1:0]    result_reg, result_next;

    logic [W-1:0]    add_a, add_b;
    logic            add_cin;
    logic [W:0]      sum;
    logic [W-1:0]    rem_sh;
    logic [W-1:0]    mag_a, mag_b;

    assign rem_sh = {acc_reg[W-2:0], mplier_reg[W-1]};
    assign mag_a  = a[W-1] ? (~a + W'(1)) : a;
    assign mag_b  = b[W-1] ? (~b + W'(1)) : b;

    // one shared W-bit adder
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                add_a = a;
                if (req.op == OP_SUB)
                begin
                    add_b   = ~b;
                    add_cin = 1'b1;
                end
                else
                begin
                    add_b = b;
                end
            end
            S_ITER:
            begin
                if (op_reg == OP_DIV)
                begin
                    add_a   = rem_sh;
                    add_b   = ~mcand_reg;
                    add_cin = 1'b1;
                end
                else
                begin
                    add_a = acc_reg;
                    add_b = mplier_reg[0] ? mcand_reg : '0;
                end
            end
            S_FIX:
            begin
                add_a   = '0;
                add_b   = neg_reg ? ~mplier_reg : mplier_reg;
                add_cin = neg_reg;
            end
            default: ;
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_cin};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        dz_next     = dz_reg;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    dz_next  = 1'b0;
                    cnt_next = CntW'(VALUE_WIDTH - 1);
                    case (req.op)
                        OP_ADD, OP_SUB:
                        begin
                            result_next = sum[W-1:0];
                            state_next  = S_DONE;
                        end
                        OP_MUL:
                        begin
                            acc_next    = '0;
                            mcand_next  = a;
                            mplier_next = b;
                            state_next  = S_ITER;
                        end
                        OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                dz_next     = 1'b1;
                                result_next = b;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                acc_next    = '0;
                                mcand_next  = mag_b;
                                mplier_next = mag_a;
                                neg_next    = a[W-1] ^ b[W-1];
                                state_next  = S_ITER;
                            end
                        end
                        default:
                        begin
                            result_next = b;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_ITER:
            begin
                if (op_reg == OP_DIV)
                begin
                    // keep the difference when no borrow
                    acc_next    = sum[W] ? sum[W-1:0] : rem_sh;
                    mplier_next = {mplier_reg[W-2:0], sum[W]};
                end
                else
                begin
                    acc_next    = sum[W-1:0];
                    mcand_next  = {mcand_reg[W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[W-1:1]};
                end
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        state_next = S_FIX;
                    end
                    else
                    begin
                        result_next = sum[W-1:0];
                        state_next  = S_DONE;
                    end
                end
            end
            S_FIX:
            begin
                result_next = sum[W-1:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NONE;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            dz_reg    <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        result_reg <= result_next;
    end

    assign rsp.done     = (state_reg == S_DONE);
    assign rsp.div_zero = dz_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: rtl/four_function_calculator_core.sv
// Calculator core: key sequencer, operand state and result register
`default_nettype none

`include "four_function_calculator_core_defines.svh"

// Takes one key beat at a time and returns one result beat per key: the value on
// display and a divide-by-zero flag. Digit, clear, equals with nothing pending,
// an unused code and an operator that applies nothing go straight to the output
// stage; add, subtract, multiply and divide first pass through the shared unit,
// whose multiply and divide run a shift-add / restoring-divide loop, one bit per
// cycle. The key port is not ready while a key is in work; it is ready again
// once the result sits in the output register, even if that beat has not yet
// been taken.
module four_function_calculator_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 key_valid,
    output logic                key_ready,
    input  ffc_pkg::key_t       key,
    output logic                result_valid,
    input  wire                 result_ready,
    output ffc_pkg::result_t    result
);
    import ffc_pkg::*;

    localparam int W = VALUE_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH
    } state_t;

    state_t       state_reg, state_next;
    logic [W-1:0] entry_reg, entry_next;
    logic [W-1:0] held_reg, held_next;
    op_t          pend_reg, pend_next;
    op_t          cmd_reg, cmd_next;     // operator to store after the apply
    logic         fresh_reg, fresh_next; // next digit starts a new number
    logic         err_reg, err_next;
    logic         rv_reg, rv_next;
    result_t      result_reg, result_next;

    alu_req_t     alu_req;
    alu_rsp_t     alu_rsp;
    logic [W-1:0] alu_result;
    logic [W-1:0] entry_x10;
    logic [W-1:0] entry_done;
    logic         key_fire;

    assign key_ready  = (state_reg == ST_IDLE);
    assign key_fire   = key_valid && key_ready;
    assign entry_x10  = (entry_reg << 3) + (entry_reg << 1) + W'(key.digit_value);
    assign entry_done = alu_rsp.div_zero ? entry_reg : alu_result;

    ffc_seq_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (held_reg),
        .b      (entry_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        state_next  = state_reg;
        entry_next  = entry_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        cmd_next    = cmd_reg;
        fresh_next  = fresh_reg;
        err_next    = err_reg;
        rv_next     = rv_reg;
        result_next = result_reg;
        alu_req     = '{start: 1'b0, op: pend_reg};

        // drop the output beat once taken
        if (result_ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (key_fire)
                begin
                    err_next   = 1'b0;
                    state_next = ST_PUSH;
                    case (key.cmd)
                        CMD_DIGIT:
                        begin
                            if (key.digit_value < RADIX)
                            begin
                                entry_next = fresh_reg ? W'(key.digit_value) : entry_x10;
                                fresh_next = 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            entry_next = '0;
                            held_next  = '0;
                            pend_next  = OP_NONE;
                            fresh_next = 1'b1;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        begin
                            if (!fresh_reg && pend_reg != OP_NONE)
                            begin
                                alu_req.start = 1'b1;
                                cmd_next      = cmd_to_op(key.cmd);
                                state_next    = ST_EXEC;
                            end
                            else
                            begin
                                held_next  = entry_reg;
                                pend_next  = cmd_to_op(key.cmd);
                                fresh_next = 1'b1;
                            end
                        end
                        CMD_EQUALS:
                        begin
                            if (pend_reg != OP_NONE)
                            begin
                                alu_req.start = 1'b1;
                                cmd_next      = OP_NONE;
                                state_next    = ST_EXEC;
                            end
                            else
                            begin
                                fresh_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    entry_next = entry_done;
                    if (cmd_reg != OP_NONE)
                    begin
                        held_next = entry_done;
                    end
                    pend_next  = cmd_reg;
                    fresh_next = 1'b1;
                    err_next   = alu_rsp.div_zero;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold until the output register is free
                if (!rv_reg || result_ready)
                begin
                    result_next.display_value = DISPLAY_WIDTH'($signed(entry_reg));
                    result_next.divide_error  = err_reg;
                    rv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            entry_reg <= '0;
            held_reg  <= '0;
            pend_reg  <= OP_NONE;
            cmd_reg   <= OP_NONE;
            fresh_reg <= 1'b1;
            err_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            cmd_reg   <= cmd_next;
            fresh_reg <= fresh_next;
            err_reg   <= err_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = rv_reg;
    assign result       = result_reg;

    `FFC_ASSERT(a_busy_after_key, key_fire |=> !key_ready)
    `FFC_ASSERT(a_done_in_exec, alu_rsp.done |-> (state_reg == ST_EXEC))
    `FFC_ASSERT(a_start_on_key, alu_req.start |-> (key_valid && key_ready))
    `FFC_ASSERT_NEVER(a_exec_without_op, (state_reg == ST_EXEC) && (pend_reg == OP_NONE))

endmodule

`default_nettype wire

FILE: verif/tb_four_function_calculator_core.sv
// Testbench for the four-function calculator core: key sequences against a local predictor
`default_nettype none

module tb_four_function_calculator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ffc_pkg::*;

    localparam int          CLK_HALF_NS  = 10;
    localparam int          TIMEOUT_NS   = 8_000_000;
    localparam int          KEY_TARGET   = 440;
    localparam int          TAIL_KEYS    = 40;
    localparam int          DRAIN_CYCLES = 200;
    localparam logic [2:0]  CMD_UNUSED   = 3'd7;
    localparam logic [63:0] VAL_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_NEG1     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic    clk;
    logic    rst_n;
    logic    key_valid;
    logic    key_ready;
    key_t    key;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    key_t    pending_keys [$];
    result_t expected_results [$];
    logic    key_taken;
    int      keys_taken;
    int      total_keys;
    int      key_gap;
    int      ready_stall;
    int      errors;

    // Calculator state as the predictor sees it
    logic [63:0] calc_entry;
    logic [63:0] calc_held;
    op_t         calc_op;
    logic        calc_fresh;

    four_function_calculator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .key          (key),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF_NS clk = ~clk;

    // Apply the pending operation to the entry; return 1 on divide by zero
    function automatic logic apply_pending_op();
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [63:0] lhs_mag;
        logic [63:0] rhs_mag;
        logic [63:0] quot;
        lhs = calc_held;
        rhs = calc_entry;
        case (calc_op)
            OP_ADD: calc_entry = lhs + rhs;
            OP_SUB: calc_entry = lhs - rhs;
            OP_MUL: calc_entry = lhs * rhs;
            OP_DIV:
            begin
                if (rhs == 64'd0)
                    return 1'b1;
                lhs_mag = lhs[63] ? (64'd0 - lhs) : lhs;
                rhs_mag = rhs[63] ? (64'd0 - rhs) : rhs;
                quot = lhs_mag / rhs_mag;
                if (lhs[63] ^ rhs[63])
                    quot = 64'd0 - quot;
                calc_entry = quot;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic result_t press_key(input key_t k);
        result_t r;
        logic    div_zero;
        div_zero = 1'b0;
        case (k.cmd)
            CMD_DIGIT:
            begin
                if (k.digit_value < RADIX)
                begin
                    if (calc_fresh)
                    begin
                        calc_entry = 64'(k.digit_value);
                        calc_fresh = 1'b0;
                    end
                    else
                        calc_entry = calc_entry * RADIX + 64'(k.digit_value);
                end
            end
            CMD_CLEAR:
            begin
                calc_entry = 64'd0;
                calc_held  = 64'd0;
                calc_op    = OP_NONE;
                calc_fresh = 1'b1;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (!calc_fresh && calc_op != OP_NONE)
                    div_zero = apply_pending_op();
                calc_held = calc_entry;
                case (k.cmd)
                    CMD_ADD: calc_op = OP_ADD;
                    CMD_SUB: calc_op = OP_SUB;
                    CMD_MUL: calc_op = OP_MUL;
                    default: calc_op = OP_DIV;
                endcase
                calc_fresh = 1'b1;
            end
            CMD_EQUALS:
            begin
                div_zero   = apply_pending_op();
                calc_op    = OP_NONE;
                calc_fresh = 1'b1;
            end
            default: ;
        endcase
        r.display_value = calc_entry;
        r.divide_error  = div_zero;
        return r;
    endfunction

    function automatic logic idle_allowed();
        return pending_keys.size() >= TAIL_KEYS && (keys_taken / 48) % 3 != 1;
    endfunction

    task automatic push_key(input cmd_t c, input logic [3:0] d);
        key_t k;
        k.cmd         = c;
        k.digit_value = d;
        pending_keys.push_back(k);
    endtask

    // Type v in decimal, then extra random digits that may push it past 64 bits
    task automatic push_number(input logic [63:0] v, input int extra);
        logic [3:0]  digits [$];
        logic [63:0] rest;
        rest = v;
        do
        begin
            digits.push_front(4'(rest % RADIX));
            rest = rest / RADIX;
        end
        while (rest != 64'd0);
        repeat (extra) digits.push_back(4'($urandom_range(0, 9)));
        foreach (digits[i]) push_key(CMD_DIGIT, digits[i]);
    endtask

    task automatic push_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: push_number(64'($urandom_range(0, 999)), 0);
            4, 5:       push_number({$urandom, $urandom}, 0);
            6:          push_number({$urandom, $urandom}, $urandom_range(1, 3));
            7:          push_number(64'd0, 0);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       push_number(VAL_MIN, 0);
                    1:       push_number(VAL_MAX, 0);
                    2:       push_number(VAL_NEG1, 0);
                    default: push_number(64'd1, 0);
                endcase
            end
            default:    push_number(64'($urandom_range(0, 9)), 0);
        endcase
    endtask

    task automatic push_operator();
        push_key(cmd_t'($urandom_range(CMD_ADD, CMD_DIV)), 4'($urandom_range(0, 15)));
    endtask

    task automatic push_expression();
        int n;
        if ($urandom_range(0, 3) == 0)
            push_key(CMD_CLEAR, 4'($urandom_range(0, 15)));
        push_operand();
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            push_operator();
            // change of mind: second operator with nothing typed in between
            if ($urandom_range(0, 7) == 0)
                push_operator();
            push_operand();
        end
        if ($urandom_range(0, 3) != 0)
            push_key(CMD_EQUALS, 4'($urandom_range(0, 15)));
    endtask

    // Wraparound edges and divide by zero, each as a full clear-a-op-b-equals run
    task automatic push_boundary();
        push_key(CMD_CLEAR, 4'($urandom_range(0, 15)));
        case ($urandom_range(0, 4))
            0:
            begin
                push_number(VAL_MIN, 0);
                push_key(CMD_DIV, 4'd0);
                push_number(VAL_NEG1, 0);
            end
            1:
            begin
                push_number(VAL_MIN, 0);
                push_key(CMD_MUL, 4'd0);
                push_number(VAL_NEG1, 0);
            end
            2:
            begin
                push_number(VAL_MIN, 0);
                push_key(CMD_SUB, 4'd0);
                push_number(64'd1, 0);
            end
            3:
            begin
                push_number(VAL_MAX, 0);
                push_key(CMD_ADD, 4'd0);
                push_number(64'd1, 0);
            end
            default:
            begin
                push_operand();
                push_key(CMD_DIV, 4'd0);
                push_number(64'd0, 0);
            end
        endcase
        push_key(CMD_EQUALS, 4'd0);
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 4))
            push_key(cmd_t'($urandom_range(CMD_DIGIT, CMD_UNUSED)), 4'($urandom_range(0, 15)));
    endtask

    // Key driver
    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n && (!key_valid || key_taken))
        begin
            next_valid = 1'b0;
            if (key_gap > 0)
                key_gap = key_gap - 1;
            else if (pending_keys.size() != 0)
            begin
                key <= pending_keys.pop_front();
                next_valid = 1'b1;
                if (idle_allowed() && $urandom_range(0, 5) == 0)
                    key_gap = $urandom_range(1, 6);
            end
            key_valid <= next_valid;
        end
    end

    // Result receiver: stall in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_stall > 0)
            begin
                ready_stall = ready_stall - 1;
                result_ready <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 7) == 0)
            begin
                ready_stall = $urandom_range(0, 5);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Monitor: check result beats first, then predict the accepted key
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            key_taken <= key_valid && key_ready;
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected beat: display_value %0d divide_error %0b",
                             $time, result.display_value, result.divide_error);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.display_value !== want.display_value)
                    begin
                        $display("%0t: display_value expected %0d actual %0d",
                                 $time, want.display_value, result.display_value);
                        errors++;
                    end
                    if (result.divide_error !== want.divide_error)
                    begin
                        $display("%0t: divide_error expected %0b actual %0b",
                                 $time, want.divide_error, result.divide_error);
                        errors++;
                    end
                end
            end
            if (key_valid && key_ready)
            begin
                expected_results.push_back(press_key(key));
                keys_taken <= keys_taken + 1;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        key_valid    = 1'b0;
        key          = '0;
        result_ready = 1'b0;
        key_taken    = 1'b0;
        keys_taken   = 0;
        key_gap      = 0;
        ready_stall  = 0;
        errors       = 0;
        calc_entry   = 64'd0;
        calc_held    = 64'd0;
        calc_op      = OP_NONE;
        calc_fresh   = 1'b1;

        // Directed: every digit, ignored keys, operator chaining, divide by zero
        for (int d = 0; d <= 9; d++)
            push_key(CMD_DIGIT, 4'(d));
        push_key(CMD_DIGIT, 4'd10);
        push_key(CMD_DIGIT, 4'd15);
        push_key(cmd_t'(CMD_UNUSED), 4'd15);
        push_key(CMD_ADD, 4'd0);
        push_key(CMD_SUB, 4'd0);
        push_key(CMD_DIGIT, 4'd9);
        push_key(CMD_MUL, 4'd0);
        push_key(CMD_DIGIT, 4'd3);
        push_key(CMD_DIV, 4'd0);
        push_key(CMD_DIGIT, 4'd0);
        push_key(CMD_EQUALS, 4'd0);
        push_key(CMD_EQUALS, 4'd0);
        push_key(CMD_DIGIT, 4'd7);
        push_key(CMD_CLEAR, 4'd0);
        push_key(CMD_EQUALS, 4'd0);

        while (pending_keys.size() < KEY_TARGET)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:    push_boundary();
                3, 4, 5:    push_noise();
                default:    push_expression();
            endcase
        end
        total_keys = pending_keys.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (keys_taken < total_keys)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
